[rtl/core/adtd_pkg.sv]
// Shared types and constants for the double-tap detector core.
`default_nettype none
package adtd_pkg;

    localparam int THRESH_W   = 15;
    localparam int DEBOUNCE_W = 10;
    localparam int WINDOW_W   = 12;
    localparam int CLICK_W    = 3;
    localparam int REG_IDX_W  = 2;

    localparam logic [THRESH_W-1:0]   THRESH_RESET   = THRESH_W'(45);
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = WINDOW_W'(300);

    localparam logic [CLICK_W-1:0] CLICK_MAX    = 3'd7;
    localparam logic [CLICK_W-1:0] CLICK_DOUBLE = 3'd2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_REF_X     = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_DEBOUNCE  = 2'd2,
        REG_WINDOW    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DOWN  = 2'd1,
        PH_UP    = 2'd2,
        PH_COUNT = 2'd3
    } phase_t;

    typedef struct packed {
        logic               tap;
        phase_t             phase;
        logic [CLICK_W-1:0] clicks;
    } click_status_t;

endpackage
`default_nettype wire

[rtl/core/adtd_motion.sv]
// Motion level: absolute deviation of a sample from the reference against a threshold.
`default_nettype none
module adtd_motion #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic signed [SAMPLE_BITS-1:0]        accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0]        ref_x,
    input  wire logic [adtd_pkg::THRESH_W-1:0]        motion_threshold,
    output logic                                      motion
);
    import adtd_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int CMP_W  = (DIFF_W > THRESH_W) ? DIFF_W : THRESH_W;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;

    always_comb
    begin
        diff = DIFF_W'(accel_x) - DIFF_W'(ref_x);
        mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        motion = CMP_W'(mag) > CMP_W'(motion_threshold);
    end

endmodule
`default_nettype wire

[rtl/core/adtd_click_fsm.sv]
// Click state machine with debounce and tap window timing.
`default_nettype none
module adtd_click_fsm #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic                              level,
    input  wire logic [TIME_BITS-1:0]              now_ms,
    input  wire logic [adtd_pkg::DEBOUNCE_W-1:0]   debounce_ms,
    input  wire logic [adtd_pkg::WINDOW_W-1:0]     tap_window_ms,
    output adtd_pkg::click_status_t                status
);
    import adtd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [CLICK_W-1:0]   clicks_reg, clicks_next;
    logic                 tap;
    logic [TIME_BITS-1:0] wait_ms;
    logic                 debounced;
    logic                 window_over;

    always_comb
    begin
        wait_ms     = now_ms - start_reg;
        debounced   = wait_ms >= TIME_BITS'(debounce_ms);
        window_over = wait_ms > TIME_BITS'(tap_window_ms);
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (level)
                    phase_next = PH_DOWN;
            end
            PH_DOWN:
            begin
                if (!level && debounced)
                    phase_next = PH_UP;
            end
            PH_UP:
            begin
                if (debounced)
                    phase_next = PH_COUNT;
            end
            PH_COUNT:
            begin
                if (level)
                    phase_next = PH_DOWN;
                else if (window_over || clicks_reg == CLICK_DOUBLE)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        start_next  = start_reg;
        clicks_next = clicks_reg;
        tap         = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (level)
                begin
                    start_next  = now_ms;
                    clicks_next = '0;
                end
            end
            PH_DOWN:
            begin
                if (!level && debounced)
                    start_next = now_ms;
            end
            PH_UP:
            begin
                if (debounced && clicks_reg != CLICK_MAX)
                    clicks_next = clicks_reg + CLICK_W'(1);
            end
            PH_COUNT:
            begin
                if (level)
                    start_next = now_ms;
                else if (window_over || clicks_reg == CLICK_DOUBLE)
                begin
                    tap         = clicks_reg == CLICK_DOUBLE;
                    clicks_next = '0;
                    start_next  = '0;
                end
            end
            default:
            begin
                tap = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            start_reg  <= '0;
            clicks_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            clicks_reg <= clicks_next;
        end
    end

    assign status = '{tap: tap, phase: phase_next, clicks: clicks_next};

endmodule
`default_nettype wire

[rtl/core/accel_double_tap_detector_core.sv]
// Top level of the accelerometer double-tap detector core.
`default_nettype none
// Takes one X sample with its millisecond timestamp per beat and returns one result beat per
// sample: motion level, double-tap pulse, click phase and click count after that sample. A new
// sample is accepted every clock cycle unless the output stalls; each beat passes an input
// register and then a result register. The throughput is set by the click state update, which
// is combinational between the two registers. Configuration writes take effect at once and
// belong in idle periods.
module accel_double_tap_detector_core #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // accel_x, now_ms
    input  wire logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // motion, double_tap, phase, click_count
    output logic [7:0]                                 m_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [adtd_pkg::REG_IDX_W-1:0]        cfg_index,
    input  wire logic [((SAMPLE_BITS > adtd_pkg::THRESH_W) ?
                        SAMPLE_BITS : adtd_pkg::THRESH_W)-1:0] cfg_data
);
    import adtd_pkg::*;

    localparam int OUT_W = 1 + 1 + 2 + CLICK_W;

    logic signed [SAMPLE_BITS-1:0] ref_x_reg;
    logic [THRESH_W-1:0]           thresh_reg;
    logic [DEBOUNCE_W-1:0]         debounce_reg;
    logic [WINDOW_W-1:0]           window_reg;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_accel_reg;
    logic [TIME_BITS-1:0]          in_now_reg;
    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;

    logic                          out_free;
    logic                          advance;
    logic                          motion;
    click_status_t                 status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg    <= '0;
            thresh_reg   <= THRESH_RESET;
            debounce_reg <= DEBOUNCE_RESET;
            window_reg   <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_REF_X:     ref_x_reg    <= cfg_data[SAMPLE_BITS-1:0];
                REG_THRESHOLD: thresh_reg   <= cfg_data[THRESH_W-1:0];
                REG_DEBOUNCE:  debounce_reg <= cfg_data[DEBOUNCE_W-1:0];
                REG_WINDOW:    window_reg   <= cfg_data[WINDOW_W-1:0];
                default:       ref_x_reg    <= ref_x_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_accel_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_now_reg   <= s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
        end
    end

    adtd_motion #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_motion (
        .accel_x          (in_accel_reg),
        .ref_x            (ref_x_reg),
        .motion_threshold (thresh_reg),
        .motion           (motion)
    );

    adtd_click_fsm #(
        .TIME_BITS(TIME_BITS)
    ) u_click_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .level         (motion),
        .now_ms        (in_now_reg),
        .debounce_ms   (debounce_reg),
        .tap_window_ms (window_reg),
        .status        (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {status.clicks, status.phase, status.tap, motion};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 8'(out_data_reg);

    a_idle_no_clicks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:2] == PH_IDLE |-> m_tdata[6:4] == 3'd0)
        else $error("idle phase reported with nonzero click count");

    a_tap_ends_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> !m_tdata[0] && m_tdata[3:2] == PH_IDLE)
        else $error("double tap reported outside a quiet return to idle");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the result stage can drain");

endmodule
`default_nettype wire

[tb/accel_double_tap_detector_core_checker.sv]
// Checker for the double-tap detector core: click-machine predictor and result scoreboard.
module accel_double_tap_detector_core_checker
    import adtd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // accel_x, now_ms
    input  wire logic [47:0]          s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // motion, double_tap, phase, click_count
    input  wire logic [7:0]           m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    output int                        pending,
    output int                        errors
);

    typedef struct packed {
        logic [CLICK_W-1:0] clicks;
        phase_t             phase;
        logic               tap;
        logic               motion;
    } tap_result_t;

    logic signed [15:0]    ref_x;
    logic [THRESH_W-1:0]   threshold;
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [WINDOW_W-1:0]   window_ms;

    phase_t                phase;
    logic [31:0]           start_ms;
    logic [CLICK_W-1:0]    clicks;

    tap_result_t           tap_expect_q[$];
    int                    mismatches;

    function automatic tap_result_t advance_click_fsm(logic signed [15:0] x, logic [31:0] now);
        tap_result_t res;
        int          dev;
        logic [31:0] elapsed;
        logic        level;
        dev = int'(x) - int'(ref_x);
        if (dev < 0)
            dev = -dev;
        level   = dev > int'(threshold);
        elapsed = now - start_ms;
        res.tap = 1'b0;
        case (phase)
            PH_IDLE:
                if (level)
                begin
                    phase    = PH_DOWN;
                    start_ms = now;
                    clicks   = '0;
                end
            PH_DOWN:
                if (!level && elapsed >= debounce_ms)
                begin
                    phase    = PH_UP;
                    start_ms = now;
                end
            PH_UP:
                // a bounce inside the debounce time holds, as does a quiet short wait
                if (elapsed >= debounce_ms)
                begin
                    if (clicks != CLICK_MAX)
                        clicks = clicks + 1'b1;
                    phase = PH_COUNT;
                end
            default:
                if (level)
                begin
                    phase    = PH_DOWN;
                    start_ms = now;
                end
                else if (elapsed > window_ms || clicks == CLICK_DOUBLE)
                begin
                    res.tap  = (clicks == CLICK_DOUBLE);
                    phase    = PH_IDLE;
                    clicks   = '0;
                    start_ms = '0;
                end
        endcase
        res.motion = level;
        res.phase  = phase;
        res.clicks = clicks;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tap_result_t want;
        tap_result_t got;
        if (!rst_n)
        begin
            ref_x       = '0;
            threshold   = THRESH_RESET;
            debounce_ms = DEBOUNCE_RESET;
            window_ms   = WINDOW_RESET;
            phase       = PH_IDLE;
            start_ms    = '0;
            clicks      = '0;
            mismatches  = 0;
            tap_expect_q.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REF_X:     ref_x       = cfg_data;
                    REG_THRESHOLD: threshold   = cfg_data[THRESH_W-1:0];
                    REG_DEBOUNCE:  debounce_ms = cfg_data[DEBOUNCE_W-1:0];
                    REG_WINDOW:    window_ms   = cfg_data[WINDOW_W-1:0];
                    default:       ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got = tap_result_t'(m_tdata[6:0]);
                if (tap_expect_q.size() == 0)
                begin
                    $display("%0t: result beat with none expected: got %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = tap_expect_q.pop_front();
                    if (got.motion !== want.motion || got.tap !== want.tap ||
                        got.phase !== want.phase || got.clicks !== want.clicks)
                    begin
                        $display("%0t: expected motion=%0d tap=%0d phase=%0d clicks=%0d, %s",
                                 $time, want.motion, want.tap, want.phase, want.clicks,
                                 $sformatf("got motion=%0d tap=%0d phase=%0d clicks=%0d",
                                           got.motion, got.tap, got.phase, got.clicks));
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                tap_expect_q.push_back(advance_click_fsm(s_tdata[15:0], s_tdata[47:16]));

            pending <= tap_expect_q.size();
            errors  <= mismatches;
        end
    end

endmodule

[tb/accel_double_tap_detector_core_tb.sv]
// Testbench top for the double-tap detector core: reset, configuration, stimulus and verdict.
module accel_double_tap_detector_core_tb;
    import adtd_pkg::*;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int LONG_HOLD  = 300;
    localparam int PHASE_BEATS = 100;

    typedef enum {FLOW_RANDOM, FLOW_SQUEEZE, FLOW_STEADY} flow_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we    = 1'b0;
    reg_idx_t    cfg_index = REG_REF_X;
    logic [15:0] cfg_data  = '0;

    int          pending;
    int          errors;

    int          cur_ref = 0;
    int          cur_thr = THRESH_RESET;
    int          cur_deb = DEBOUNCE_RESET;
    int          cur_win = WINDOW_RESET;
    logic [31:0] t_now = '0;
    int          beats_sent = 0;
    bit          steady_tx = 1'b0;
    bit          steady_rx = 1'b0;
    bit          hold_off_req = 1'b0;

    always #1 clk = ~clk;

    accel_double_tap_detector_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    accel_double_tap_detector_core_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_tx || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int level_sample(bit loud);
        int mag;
        int v;
        if (loud)
            mag = cur_thr + 1 + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 300));
        else
            mag = ($urandom_range(0, 7) == 0) ? cur_thr : $urandom_range(0, cur_thr);
        v = $urandom_range(0, 1) ? cur_ref + mag : cur_ref - mag;
        if (v > SAMPLE_MAX || v < SAMPLE_MIN)
            v = 2 * cur_ref - v;
        if (v > SAMPLE_MAX || v < SAMPLE_MIN)
            v = (loud == (cur_ref < 0)) ? SAMPLE_MAX : SAMPLE_MIN;
        return v;
    endfunction

    task automatic send_sample(int x, logic [31:0] stamp);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, x[15:0]};
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
        gap = tx_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(int ref_val, int thr, int deb, int win);
        logic [15:0] vals[reg_idx_t];
        reg_idx_t    idx;
        vals[REG_REF_X]     = ref_val[15:0];
        vals[REG_THRESHOLD] = thr[15:0];
        vals[REG_DEBOUNCE]  = deb[15:0];
        vals[REG_WINDOW]    = win[15:0];
        idx = idx.first();
        do
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_we  <= 1'b0;
        cur_ref = ref_val;
        cur_thr = thr;
        cur_deb = deb;
        cur_win = win;
    endtask

    task automatic hold_level(bit loud, int dur);
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            t_now += dur / n + $urandom_range(0, 1);
            send_sample(level_sample(($urandom_range(0, 9) == 0) ? !loud : loud), t_now);
        end
    endtask

    task automatic play_taps();
        int presses;
        presses = $urandom_range(1, 4);
        for (int i = 0; i < presses; i++)
        begin
            hold_level(1'b1, $urandom_range(cur_deb / 2, 2 * cur_deb + 2));
            hold_level(1'b0, $urandom_range(cur_deb, cur_deb + cur_win / 2 + 2));
        end
        hold_level(1'b0, cur_deb + cur_win + 4);
    endtask

    // press, release past debounce, count, then press again at once
    task automatic rapid_clicks(int n);
        for (int i = 0; i < n; i++)
        begin
            t_now += 1;
            send_sample(level_sample(1'b1), t_now);
            t_now += cur_deb;
            send_sample(level_sample(1'b0), t_now);
            t_now += cur_deb;
            send_sample(level_sample(1'b0), t_now);
        end
        t_now += cur_win + 1;
        send_sample(level_sample(1'b0), t_now);
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1))
                t_now += $urandom_range(0, 3 * cur_deb + 10);
            else
                t_now = $urandom;
            send_sample($urandom_range(0, 65535), t_now);
        end
    endtask

    task automatic run_phase(int ref_val, int thr, int deb, int win, flow_t flow);
        int r;
        int target;
        drain();
        apply_setting(ref_val, thr, deb, win);
        t_now     = $urandom;
        steady_rx = (flow == FLOW_STEADY);
        steady_tx = (flow != FLOW_RANDOM);
        if (flow == FLOW_SQUEEZE)
            hold_off_req = 1'b1;
        target = beats_sent + PHASE_BEATS;
        while (beats_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                play_taps();
            else if (r < 75)
                rapid_clicks($urandom_range(1, 9));
            else if (r < 93)
                noise_burst();
            else
                drain();
        end
        steady_rx = 1'b0;
        steady_tx = 1'b0;
    endtask

    initial
    begin : receiver
        int  n;
        int  r;
        bit  rdy;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rdy = 1'b0;
                n   = LONG_HOLD;
            end
            else if (steady_rx || r < 60)
            begin
                rdy = 1'b1;
                n   = steady_rx ? 1 : $urandom_range(1, 12);
            end
            else
            begin
                rdy = 1'b0;
                n   = (r < 90) ? $urandom_range(1, 3) :
                      (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
            end
            m_tready <= rdy;
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: threshold edges, sample extremes, a bounce, a lone click
        send_sample(0, 32'd0);
        send_sample(45, 32'd1);
        send_sample(-45, 32'd2);
        send_sample(-46, 32'd3);
        send_sample(SAMPLE_MAX, 32'd20);
        send_sample(SAMPLE_MIN, 32'd40);
        send_sample(0, 32'd60);
        send_sample(46, 32'd70);
        send_sample(0, 32'd110);
        send_sample(0, 32'd411);

        // double tap across the timestamp wrap
        send_sample(100, 32'hFFFF_FFE0);
        send_sample(100, 32'hFFFF_FFFF);
        send_sample(0, 32'h0000_0012);
        send_sample(0, 32'h0000_0044);
        send_sample(-100, 32'h0000_0045);
        send_sample(0, 32'h0000_0077);
        send_sample(0, 32'h0000_00A9);
        send_sample(0, 32'h0000_00AA);

        run_phase(SAMPLE_MIN, 32767, 0, 0, FLOW_RANDOM);
        run_phase(SAMPLE_MAX, 0, 1023, 4095, FLOW_RANDOM);
        run_phase(0, 45, 50, 300, FLOW_SQUEEZE);
        run_phase($urandom_range(0, 65535) - 32768, $urandom_range(0, 2000),
                  $urandom_range(0, 1023), $urandom_range(0, 4095), FLOW_STEADY);
        run_phase($urandom_range(0, 65535) - 32768, $urandom_range(0, 32767),
                  $urandom_range(0, 1023), $urandom_range(0, 4095), FLOW_RANDOM);
        run_phase($urandom_range(0, 65535) - 32768, 200, 5, 40, FLOW_RANDOM);
        drain();

        if (errors == 0)
            $display("accel_double_tap_detector_core_tb OK");
        else
            $display("accel_double_tap_detector_core_tb NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("accel_double_tap_detector_core_tb NOT OK");
        $finish;
    end

endmodule
